// ----- rtl/tea_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA cipher package
// Shared types and constants for the TEA block cipher with CBC chaining.
// ----------------------------------------------------------------------------
package tea_pkg;

  // Round constant added to (encrypt) or subtracted from (decrypt) the running sum once per TEA cycle.
  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BLOCK_W = 64;
  localparam int unsigned CYCLE_W = 7;
  localparam int unsigned CFG_AW  = 3;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_KEY0      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KEY1      = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KEY2      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KEY3      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CYCLES    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CHAINING  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_IV        = 3'd6;

  localparam logic [CYCLE_W-1:0] CYCLES_RESET = 7'd32;

  // Key words, index 0 is the first big-endian word.
  typedef logic [3:0][WORD_W-1:0] key_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_FIN  = 2'd2
  } state_t;

endpackage

// ----- rtl/tea_block_cipher_cbc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA block cipher with CBC chaining
// Iterative TEA engine, one cipher cycle per clock, optional CBC mode.
// ----------------------------------------------------------------------------
// Usage:
// A block enters on the in_ stream when in_tvalid and in_tready are high;
// in_tuser carries the opcode (bit 0, 1 = decrypt) and the new-message flag
// (bit 1, reloads the chain from the IV). The result leaves on the out_
// stream. One shared round unit computes one full TEA cycle per clock. The
// next block is taken once the result of the one before it is registered;
// in_tready is low while a block is in flight. The result sits in an output
// register: a stalled receiver does not block the next input transfer, but a
// finished block waits in the final state until the output register is free.
// Configuration writes go through cfg_we, cfg_addr and cfg_wdata and are
// applied at once; write them only when idle. Synchronous reset clears the
// key, IV and chain to zero, loads the CYCLES_RESET cycle count, selects ECB
// mode, and empties the output register.
// ----------------------------------------------------------------------------
module tea_block_cipher_cbc (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] in_block
  input  logic [1:0]  in_tuser,   // [0] opcode, [1] new_message
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] out_block
  // Configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  // Configuration registers
  tea_pkg::key_t  key_r;
  logic [6:0]     cycle_count_r;
  logic           chaining_on_r;
  logic [63:0]    iv_r;

  // Sequencer and datapath registers
  tea_pkg::state_t state_r;
  tea_pkg::state_t state_nxt;
  logic [6:0]      cnt_r;
  logic [31:0]     v0_r;
  logic [31:0]     v1_r;
  logic [31:0]     sum_r;
  logic [63:0]     blk_r;
  tea_pkg::op_t    op_r;
  logic [63:0]     chain_r;
  logic [63:0]     out_data_r;
  logic            out_valid_r;

  // Control decode
  logic            accept;
  logic            step_en;
  logic            fin_en;
  logic            out_free;

  // Derived values
  tea_pkg::op_t    in_op;
  logic            in_new_msg;
  logic [63:0]     chain_eff;
  logic [63:0]     start_blk;
  logic [31:0]     dec_sum0;
  logic [31:0]     round_v0;
  logic [31:0]     round_v1;
  logic [63:0]     result;

  assign in_op      = tea_pkg::op_t'(in_tuser[0]);
  assign in_new_msg = in_tuser[1];
  assign out_free   = !out_valid_r || out_tready;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r         <= '0;
      cycle_count_r <= tea_pkg::CYCLES_RESET;
      chaining_on_r <= 1'b0;
      iv_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tea_pkg::REG_KEY0:     key_r[0]      <= cfg_wdata[31:0];
        tea_pkg::REG_KEY1:     key_r[1]      <= cfg_wdata[31:0];
        tea_pkg::REG_KEY2:     key_r[2]      <= cfg_wdata[31:0];
        tea_pkg::REG_KEY3:     key_r[3]      <= cfg_wdata[31:0];
        tea_pkg::REG_CYCLES:   cycle_count_r <= cfg_wdata[6:0];
        tea_pkg::REG_CHAINING: chaining_on_r <= cfg_wdata[0];
        tea_pkg::REG_IV:       iv_r          <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tea_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (cycle_count_r == 7'd0) ? tea_pkg::S_FIN : tea_pkg::S_RUN;
        end
      end
      tea_pkg::S_RUN: begin
        if (cnt_r == 7'd1) begin
          state_nxt = tea_pkg::S_FIN;
        end
      end
      tea_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = tea_pkg::S_IDLE;
        end
      end
      default: state_nxt = tea_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    step_en   = 1'b0;
    fin_en    = 1'b0;
    unique case (state_r)
      tea_pkg::S_IDLE: in_tready = 1'b1;
      tea_pkg::S_RUN:  step_en   = 1'b1;
      tea_pkg::S_FIN:  fin_en    = out_free;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tea_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Chain value after an optional reload, and the block entering the cipher.
  assign chain_eff = in_new_msg ? iv_r : chain_r;
  assign start_blk = (chaining_on_r && in_op == tea_pkg::OP_ENCRYPT) ?
                     (in_tdata ^ chain_eff) : in_tdata;
  assign dec_sum0  = 32'(tea_pkg::TEA_DELTA * 32'(cycle_count_r));

  // Shared round unit.
  tea_round u_round (
    .v0_i  (v0_r),
    .v1_i  (v1_r),
    .sum_i (sum_r),
    .key_i (key_r),
    .op_i  (op_r),
    .v0_o  (round_v0),
    .v1_o  (round_v1)
  );

  // Load on transfer, then one cipher cycle per clock.
  always_ff @(posedge clk) begin
    if (accept) begin
      v0_r  <= start_blk[63:32];
      v1_r  <= start_blk[31:0];
      blk_r <= in_tdata;
      op_r  <= in_op;
      sum_r <= (in_op == tea_pkg::OP_DECRYPT) ? dec_sum0 : tea_pkg::TEA_DELTA;
    end else if (step_en) begin
      v0_r  <= round_v0;
      v1_r  <= round_v1;
      sum_r <= (op_r == tea_pkg::OP_DECRYPT) ? (sum_r - tea_pkg::TEA_DELTA) :
                                               (sum_r + tea_pkg::TEA_DELTA);
    end
  end

  // Remaining cipher cycles.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cycle_count_r;
    end else if (step_en) begin
      cnt_r <= cnt_r - 7'd1;
    end
  end

  // Decryption in CBC mode XORs the chain after the cipher.
  assign result = {v0_r, v1_r} ^
                  ((chaining_on_r && op_r == tea_pkg::OP_DECRYPT) ? chain_r : 64'd0);

  // Chain register: reload at message start, update when a block finishes in CBC mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (accept && in_new_msg) begin
      chain_r <= iv_r;
    end else if (fin_en && chaining_on_r) begin
      chain_r <= (op_r == tea_pkg::OP_DECRYPT) ? blk_r : result;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_en) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // A transfer with a nonzero cycle count starts the iteration.
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cycle_count_r != 7'd0 |=> state_r == tea_pkg::S_RUN)
    else $error("transfer did not start the cipher iteration");

  // The cycle counter never sits at zero while iterating.
  a_run_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tea_pkg::S_RUN |-> cnt_r != 7'd0)
    else $error("iteration running with no cycles left");

  // Each iteration step counts down by one and keeps running until the last.
  a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tea_pkg::S_RUN && cnt_r != 7'd1 |=>
      state_r == tea_pkg::S_RUN && cnt_r == $past(cnt_r) - 7'd1)
    else $error("iteration counter stepped incorrectly");

  // A finished block lands in the output register and frees the engine.
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tea_pkg::S_FIN && out_free |=>
      out_valid_r && state_r == tea_pkg::S_IDLE)
    else $error("finished block was not delivered to the output register");
`endif

endmodule

// ----- rtl/tea_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TEA round unit
// One full TEA cycle (two Feistel half-steps), forward or inverse.
// ----------------------------------------------------------------------------
module tea_round (
  input  logic [31:0]     v0_i,
  input  logic [31:0]     v1_i,
  input  logic [31:0]     sum_i,
  input  tea_pkg::key_t   key_i,
  input  tea_pkg::op_t    op_i,
  output logic [31:0]     v0_o,
  output logic [31:0]     v1_o
);

  // TEA mixing function of one half-step.
  function automatic logic [31:0] mix(input logic [31:0] v, input logic [31:0] s,
                                      input logic [31:0] ka, input logic [31:0] kb);
    mix = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

  logic [31:0] enc_v0;
  logic [31:0] enc_v1;
  logic [31:0] dec_v0;
  logic [31:0] dec_v1;

  // Encryption updates v0 first, then v1 with the new v0.
  assign enc_v0 = v0_i + mix(v1_i, sum_i, key_i[0], key_i[1]);
  assign enc_v1 = v1_i + mix(enc_v0, sum_i, key_i[2], key_i[3]);

  // Decryption undoes v1 first, then v0 with the restored v1.
  assign dec_v1 = v1_i - mix(v0_i, sum_i, key_i[2], key_i[3]);
  assign dec_v0 = v0_i - mix(dec_v1, sum_i, key_i[0], key_i[1]);

  assign v0_o = (op_i == tea_pkg::OP_DECRYPT) ? dec_v0 : enc_v0;
  assign v1_o = (op_i == tea_pkg::OP_DECRYPT) ? dec_v1 : enc_v1;

endmodule
